>>> hdl/slab_bitmap_allocator_assert.svh
// assertion macros for the slab bitmap allocator
// expects signals named clk and rst in the including scope
`ifndef SLAB_BITMAP_ALLOCATOR_ASSERT_SVH
`define SLAB_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off while in reset
`define SBA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sba assertion failed");

// next-cycle implication, off while in reset
`define SBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sba assertion failed");

`endif

>>> hdl/sba_pkg.sv
// shared types, constants and helpers of the slab bitmap allocator
// no dependencies
`default_nettype none

package sba_pkg;

  localparam int ADDR_W    = 64;
  localparam int SIZE_W    = 13;
  localparam int STATUS_W  = 2;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd8;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_BASE = 1'b0,
    REG_SLOT_SIZE   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // a size of zero behaves as one
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    eff_size = (s == '0) ? SIZE_W'(1) : s;
  endfunction

  // position of the lowest clear bit; word must have one
  function automatic logic [BIT_W-1:0] lowest_clear(input word_t w);
    word_t inv;
    word_t low;
    logic [BIT_W-1:0] pos;
    inv = ~w;
    low = inv & (~inv + word_t'(1));
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        pos = pos | BIT_W'(i);
      end
    end
    lowest_clear = pos;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sba_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/sba_front.sv
// request front end: range check of frees and a two-entry request queue
// depends on sba_pkg
`default_nettype none

module sba_front #(
  parameter int MAP_WORDS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      op,
  input  logic [sba_pkg::ADDR_W-1:0] address,
  output logic                      full,
  input  logic [sba_pkg::ADDR_W-1:0] region_base,
  input  logic [sba_pkg::SIZE_W-1:0] slot_size,
  output logic                      q_valid,
  input  logic                      q_pop,
  output logic                      q_op,
  output logic                      q_range_err,
  output logic [sba_pkg::SIZE_W + ((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)
                + sba_pkg::BIT_W - 1:0] q_offset
);

  import sba_pkg::*;

  localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W  = WORD_W + BIT_W;
  localparam int DIV_W  = SIZE_W + IDX_W;
  localparam int NOBJ   = MAP_WORDS * WORD_BITS;

  // one past the last object's offset, follows the size register
  logic [DIV_W-1:0] limit;

  assign limit = DIV_W'(eff_size(slot_size)) * DIV_W'(NOBJ);

  // classify the incoming word
  logic [ADDR_W-1:0] offset;
  logic              below;
  logic              range_err;

  always_comb begin
    offset    = address - region_base;
    below     = address < region_base;
    range_err = (op == OP_FREE) && (below || (offset >= ADDR_W'(limit)));
  end

  // two-entry request queue
  logic             e_op   [2];
  logic             e_err  [2];
  logic [DIV_W-1:0] e_off  [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  assign q_op        = e_op[rd_ptr];
  assign q_range_err = e_err[rd_ptr];
  assign q_offset    = e_off[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      e_op[wr_ptr]  <= op;
      e_err[wr_ptr] <= range_err;
      e_off[wr_ptr] <= offset[DIV_W-1:0];
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/sba_back.sv
// request back end: bitmap word scan, free-index divider, address multiply
// depends on sba_pkg and sba_ram
`default_nettype none

module sba_back #(
  parameter int MAP_WORDS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic                      q_op,
  input  logic                      q_range_err,
  input  logic [sba_pkg::SIZE_W + ((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)
                + sba_pkg::BIT_W - 1:0] q_offset,
  input  logic [sba_pkg::ADDR_W-1:0] region_base,
  input  logic [sba_pkg::SIZE_W-1:0] slot_size,
  input  logic                      pop,
  output logic                      empty,
  output logic [sba_pkg::ADDR_W-1:0] object_address,
  output logic [sba_pkg::STATUS_W-1:0] status
);

  import sba_pkg::*;

  localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W  = WORD_W + BIT_W;
  localparam int PROD_W = SIZE_W + IDX_W;
  localparam int CNT_W  = $clog2(IDX_W + 1);
  localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_MUL,
    B_ADD,
    B_DIV,
    B_FREE_RD,
    B_FREE_WR
  } state_t;

  state_t              state;
  logic [WORD_W-1:0]   wcnt;
  logic [SIZE_W-1:0]   rem;
  logic [IDX_W-1:0]    quo;
  logic [CNT_W-1:0]    cnt;
  logic [PROD_W-1:0]   prod;
  logic                res_valid;
  logic [ADDR_W-1:0]   res_addr;
  status_t             res_status;
  logic [MAP_WORDS-1:0] map_valid;
  logic                rd_valid;

  // bitmap ram ports
  logic              re;
  logic [WORD_W-1:0] raddr;
  logic              we;
  logic [WORD_W-1:0] waddr;
  word_t             wdata;
  word_t             rdata;

  sba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WORD_W)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign empty          = !res_valid;
  assign object_address = res_addr;
  assign status         = res_status;

  // word as read, never-written words read as clear
  word_t             map_word;
  logic              has_clear;
  logic [BIT_W-1:0]  bit_sel;
  logic [SIZE_W-1:0] size_e;

  always_comb begin
    map_word  = rd_valid ? rdata : '0;
    has_clear = ~&map_word;
    bit_sel   = lowest_clear(map_word);
    size_e    = eff_size(slot_size);
  end

  // one restoring divide step
  logic [SIZE_W:0]   div_try;
  logic              div_ge;
  logic [SIZE_W:0]   div_diff;
  logic [SIZE_W-1:0] rem_next;
  logic [IDX_W-1:0]  quo_next;

  always_comb begin
    div_try  = {rem, quo[IDX_W-1]};
    div_ge   = div_try >= {1'b0, size_e};
    div_diff = div_try - {1'b0, size_e};
    rem_next = div_ge ? div_diff[SIZE_W-1:0] : div_try[SIZE_W-1:0];
    quo_next = {quo[IDX_W-2:0], div_ge};
  end

  // queue pop and ram control
  always_comb begin
    q_pop = (state == B_IDLE) && q_valid && !res_valid;
    re    = 1'b0;
    raddr = wcnt;
    we    = 1'b0;
    waddr = wcnt;
    wdata = map_word | (word_t'(1) << bit_sel);
    unique case (state)
      B_IDLE: begin
        if (q_pop && (q_op == OP_ALLOC)) begin
          re    = 1'b1;
          raddr = '0;
        end
      end
      B_SCAN: begin
        if (has_clear) begin
          we = 1'b1;
        end else if (wcnt != WORD_LAST) begin
          re    = 1'b1;
          raddr = WORD_W'(wcnt + 1'b1);
        end
      end
      B_FREE_RD: begin
        re    = 1'b1;
        raddr = quo[IDX_W-1:BIT_W];
      end
      B_FREE_WR: begin
        we    = 1'b1;
        waddr = quo[IDX_W-1:BIT_W];
        wdata = map_word & ~(word_t'(1) << quo[BIT_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  // sequencer with result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
      map_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (re) begin
        rd_valid <= map_valid[raddr];
      end
      if (we) begin
        map_valid[waddr] <= 1'b1;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            if (q_op == OP_ALLOC) begin
              wcnt  <= '0;
              state <= B_SCAN;
            end else if (q_range_err) begin
              res_addr   <= '0;
              res_status <= STATUS_RANGE;
              res_valid  <= 1'b1;
            end else begin
              rem   <= q_offset[PROD_W-1:IDX_W];
              quo   <= q_offset[IDX_W-1:0];
              cnt   <= CNT_W'(IDX_W - 1);
              state <= B_DIV;
            end
          end
        end
        B_SCAN: begin
          if (has_clear) begin
            quo   <= {wcnt, bit_sel};
            state <= B_MUL;
          end else if (wcnt == WORD_LAST) begin
            res_addr   <= '0;
            res_status <= STATUS_FULL;
            res_valid  <= 1'b1;
            state      <= B_IDLE;
          end else begin
            wcnt <= WORD_W'(wcnt + 1'b1);
          end
        end
        B_MUL: begin
          prod  <= PROD_W'(size_e) * PROD_W'(quo);
          state <= B_ADD;
        end
        B_ADD: begin
          res_addr   <= region_base + ADDR_W'(prod);
          res_status <= STATUS_OK;
          res_valid  <= 1'b1;
          state      <= B_IDLE;
        end
        B_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          if (cnt == '0) begin
            state <= B_FREE_RD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        B_FREE_RD: begin
          state <= B_FREE_WR;
        end
        B_FREE_WR: begin
          res_addr   <= '0;
          res_status <= STATUS_OK;
          res_valid  <= 1'b1;
          state      <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/slab_bitmap_allocator.sv
// top level of the slab bitmap allocator: config registers, front and back
// depends on sba_pkg, sba_front, sba_back and the assertion header
//
// Requests come in as words on push/full: op 0 allocates the lowest free
// object, op 1 frees the object holding address. Each request gives one
// result word on empty/pop: object_address and status (0 ok, 1 slab full,
// 2 free address out of range). Results leave in request order.
// region_base (index 0) and the slot size (index 1) are written on the
// cfg_valid/cfg_ready channel, which is always ready; write them only
// while no request is in flight.
// With the back end idle, an allocate reads the bitmap words in turn (1 to
// MAP_WORDS, one per cycle), then does a multiply and an add; a full slab
// gives its result once all MAP_WORDS words are read. A free runs the one
// bit per cycle divider over IDX_W = clog2(MAP_WORDS) + 5 quotient bits,
// then a bitmap read-modify-write; an out of range free skips both and
// sets its result from the idle state. One at a time.
// A two-entry request queue keeps taking words while a result waits; when
// the receiver stalls, the back end holds its single result and the queue
// fills, then full rises. Reset empties both sides, marks every object
// free and loads region_base 0, slot size 8.
`default_nettype none

module slab_bitmap_allocator #(
  parameter int MAP_WORDS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          op,
  input  logic [sba_pkg::ADDR_W-1:0]    address,
  output logic                          empty,
  input  logic                          pop,
  output logic [sba_pkg::ADDR_W-1:0]    object_address,
  output logic [sba_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sba_pkg::ADDR_W-1:0]    cfg_data
);

  import sba_pkg::*;

  `include "slab_bitmap_allocator_assert.svh"

  localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int DIV_W  = SIZE_W + WORD_W + BIT_W;

  // configuration registers
  logic [ADDR_W-1:0] region_base;
  logic [SIZE_W-1:0] slot_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      slot_size   <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REGION_BASE: region_base <= cfg_data;
        REG_SLOT_SIZE:   slot_size   <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request queue between front and back
  logic             q_valid;
  logic             q_pop;
  logic             q_op;
  logic             q_range_err;
  logic [DIV_W-1:0] q_offset;

  sba_front #(
    .MAP_WORDS (MAP_WORDS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .op          (op),
    .address     (address),
    .full        (full),
    .region_base (region_base),
    .slot_size   (slot_size),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_op        (q_op),
    .q_range_err (q_range_err),
    .q_offset    (q_offset)
  );

  sba_back #(
    .MAP_WORDS (MAP_WORDS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_op           (q_op),
    .q_range_err    (q_range_err),
    .q_offset       (q_offset),
    .region_base    (region_base),
    .slot_size      (slot_size),
    .pop            (pop),
    .empty          (empty),
    .object_address (object_address),
    .status         (status)
  );

  // back end starts a request only with its result slot free
  `SBA_ASSERT_IMPLY(a_start_slot_free, q_pop, q_valid && empty)
  // a failed request or a free never returns an address
  `SBA_ASSERT_IMPLY(a_fail_zero_addr, !empty && (status != STATUS_OK), object_address == '0)
  // one result slot: a taken result leaves it empty in the next cycle
  `SBA_ASSERT_NEXT(a_pop_drains, pop && !empty, empty)

endmodule

`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for the slab bitmap allocator
// depends on sba_pkg and slab_bitmap_allocator; predicts every result word
// from a shadow copy of the used bitmap and the two config registers
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sba_pkg::*;

  localparam int MAP_WORDS      = 16;
  localparam int OBJECTS        = MAP_WORDS * WORD_BITS;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [ADDR_W-1:0] object_address;
    status_t           status;
  } slab_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic                 op = 1'b0;
  logic [ADDR_W-1:0]    address = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [ADDR_W-1:0]    object_address;
  logic [STATUS_W-1:0]  status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  // shadow of the allocator state
  word_t             shadow_map [MAP_WORDS];
  logic [ADDR_W-1:0] shadow_base = '0;
  logic [SIZE_W-1:0] shadow_size = SIZE_RESET;

  slab_reply_t replies_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned alloc_words   = 0;
  int unsigned free_words    = 0;
  int unsigned replies_seen  = 0;
  int unsigned full_replies  = 0;
  int unsigned range_replies = 0;
  int unsigned reg_writes    = 0;
  int unsigned quiet_cycles  = 0;

  slab_bitmap_allocator #(
    .MAP_WORDS(MAP_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .op(op),
    .address(address),
    .empty(empty),
    .pop(pop),
    .object_address(object_address),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // expected reply for one request, updating the shadow bitmap
  function automatic slab_reply_t predict_reply(input op_t kind, input logic [ADDR_W-1:0] addr);
    slab_reply_t       reply;
    logic [ADDR_W-1:0] sz;
    logic [ADDR_W-1:0] idx;
    bit                found;
    reply.object_address = '0;
    reply.status = STATUS_OK;
    sz = (shadow_size == '0) ? ADDR_W'(1) : ADDR_W'(shadow_size);
    found = 1'b0;
    if (kind == OP_ALLOC) begin
      alloc_words++;
      // lowest clear bit, word 0 first
      for (int w = 0; w < MAP_WORDS; w++) begin
        for (int b = 0; b < WORD_BITS; b++) begin
          if (!found && !shadow_map[w][b]) begin
            found = 1'b1;
            shadow_map[w][b] = 1'b1;
            reply.object_address = shadow_base + sz * ADDR_W'(w * WORD_BITS + b);
          end
        end
      end
      if (!found) begin
        reply.status = STATUS_FULL;
        full_replies++;
      end
    end else begin
      free_words++;
      idx = (addr - shadow_base) / sz;
      if (addr < shadow_base || idx >= ADDR_W'(OBJECTS)) begin
        reply.status = STATUS_RANGE;
        range_replies++;
      end else begin
        shadow_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
      end
    end
    return reply;
  endfunction

  // free target: mostly a live object at a random offset, else stray addresses
  function automatic logic [ADDR_W-1:0] pick_free_address();
    logic [ADDR_W-1:0] sz;
    logic [ADDR_W-1:0] r;
    int unsigned       k;
    sz = (shadow_size == '0) ? ADDR_W'(1) : ADDR_W'(shadow_size);
    r = {$urandom, $urandom};
    k = 0;
    case ($urandom_range(0, 9))
      0: return r;
      1: return (shadow_base == '0) ? r : r % shadow_base;
      2: return shadow_base + sz * ADDR_W'(OBJECTS) + r % (sz * 4);
      default: begin
        for (int t = 0; t < 8; t++) begin
          k = $urandom_range(0, OBJECTS - 1);
          if (shadow_map[k / WORD_BITS][k % WORD_BITS]) break;
        end
        return shadow_base + sz * ADDR_W'(k) + ADDR_W'($urandom) % sz;
      end
    endcase
  endfunction

  // result side: random stalls, compare each popped word with the oldest expectation
  always @(posedge clk) begin : reply_check
    slab_reply_t due;
    if (!rst && pop && !empty) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected: addr %h status %0d",
                 $time, object_address, status);
      end else begin
        due = replies_due.pop_front();
        if (object_address !== due.object_address) begin
          mismatches++;
          $display("%0t: object_address expected %h actual %h",
                   $time, due.object_address, object_address);
        end
        if (status !== due.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, due.status, status);
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // watchdog on cycles in which no word moves anywhere
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct = send_pct;
    pop_stall_pct = stall_pct;
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // one request word; push stays high into the next call unless it idles
  task automatic send_request(input op_t kind, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= kind;
    address <= addr;
    do @(posedge clk); while (full);
    replies_due.push_back(predict_reply(kind, addr));
  endtask

  // both registers, written back to back while the block is idle
  task automatic write_config(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_REGION_BASE;
    cfg_data <= base;
    do @(posedge clk); while (!cfg_ready);
    shadow_base = base;
    cfg_index <= REG_SLOT_SIZE;
    cfg_data <= ADDR_W'(size);
    do @(posedge clk); while (!cfg_ready);
    shadow_size = size;
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  task automatic random_traffic(input int unsigned count, input int unsigned alloc_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) wait_drained();
      if ($urandom_range(0, 99) < alloc_pct) send_request(OP_ALLOC, {$urandom, $urandom});
      else send_request(OP_FREE, pick_free_address());
    end
  endtask

  // reset values: base 0, size 8; double and unaligned frees
  task automatic test_reset_defaults();
    set_idling(0, 0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, {$urandom, $urandom});
    send_request(OP_FREE, 64'd8);
    send_request(OP_FREE, 64'd8);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 64'd13);
    send_request(OP_FREE, '1);
    send_request(OP_FREE, 64'd4095);
    send_request(OP_FREE, 64'd4096);
  endtask

  // zero size, size 4096 and size one, base at the top so addresses wrap
  task automatic test_size_extremes();
    write_config(64'h1000, '0);
    send_request(OP_FREE, 64'h0fff);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 64'h1000 + 511);
    send_request(OP_FREE, 64'h1000 + 512);
    write_config(64'hffff_ffff_ffff_f000, 13'd4096);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);
    send_request(OP_FREE, '1);
    write_config('1, 13'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '1);
    send_request(OP_FREE, '0);
    write_config('0, 13'd4096);
    send_request(OP_FREE, 64'h1f_ffff);
    send_request(OP_FREE, 64'h20_0000);
    send_request(OP_ALLOC, '0);
  endtask

  task automatic test_mixed_traffic();
    set_idling(0, 0);
    write_config({$urandom, $urandom}, SIZE_W'($urandom_range(1, 64)));
    random_traffic(30, 65);
  endtask

  // allocate until the slab reports full several times
  task automatic test_fill_to_full();
    int unsigned full_goal;
    int unsigned guard;
    set_idling(48, 0);
    write_config({$urandom, $urandom}, 13'd4096);
    full_goal = full_replies + 4;
    guard = 0;
    while (full_replies < full_goal && guard < 1200) begin
      if ($urandom_range(0, 99) < 98) send_request(OP_ALLOC, {$urandom, $urandom});
      else send_request(OP_FREE, pick_free_address());
      guard++;
    end
  endtask

  task automatic test_free_heavy();
    set_idling(0, 48);
    write_config('0, 13'd1);
    random_traffic(30, 40);
  endtask

  task automatic test_both_idle();
    set_idling(6, 6);
    write_config({32'hffff_ffff, $urandom}, SIZE_W'($urandom_range(1, 4096)));
    random_traffic(30, 50);
  endtask

  initial begin
    for (int w = 0; w < MAP_WORDS; w++) shadow_map[w] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_size_extremes();
    test_mixed_traffic();
    test_fill_to_full();
    test_free_heavy();
    test_both_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d allocate and %0d free requests, %0d results compared",
             alloc_words, free_words, replies_seen);
    $display("slab full %0d times, %0d frees out of range, %0d register writes",
             full_replies, range_replies, reg_writes);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/sba_pkg.sv
hdl/sba_ram.sv
hdl/sba_front.sv
hdl/sba_back.sv
hdl/slab_bitmap_allocator.sv
sim/testbench.sv
